// ----- src/ll1tsr_pkg.sv -----
// Package with the symbol codes, status codes, states and grammar ROM of the LL(1) recognizer.
package ll1tsr_pkg;

  typedef logic [4:0] sym_t;
  typedef logic [4:0] rule_idx_t;
  typedef logic [2:0] rule_len_t;
  typedef logic [2:0] status_t;

  // Terminals are 0..15 with the end marker at 15; nonterminals start at 16.
  localparam sym_t SYM_END   = 5'd15;
  localparam sym_t SYM_START = 5'd16;
  localparam sym_t SYM_ZERO  = 5'd0;

  localparam logic [3:0] NT_COUNT = 4'd13;
  localparam rule_idx_t RULE_NONE  = 5'd31;
  localparam rule_idx_t RULE_COUNT = 5'd18;
  localparam int PROD_MAX = 5;

  // Result status codes.
  localparam status_t ST_CONSUMED = 3'd0;
  localparam status_t ST_ACCEPTED = 3'd1;
  localparam status_t ST_NO_RULE  = 3'd2;
  localparam status_t ST_MISMATCH = 3'd3;
  localparam status_t ST_OVERFLOW = 3'd4;
  localparam status_t ST_IGNORED  = 3'd5;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_FETCH,
    S_EVAL,
    S_PUSH,
    S_DONE
  } state_t;

  // Length of each production's right-hand side.
  localparam rule_len_t RULE_LEN [18] = '{
    3'd4, 3'd2, 3'd0, 3'd5, 3'd2, 3'd1, 3'd1, 3'd1, 3'd4,
    3'd5, 3'd5, 3'd2, 3'd3, 3'd2, 3'd3, 3'd1, 3'd1, 3'd3
  };

  // Right-hand sides, written left to right; pushed from the right end.
  localparam sym_t RULE_SYM [18][PROD_MAX] = '{
    '{5'd0,  5'd17, 5'd19, 5'd1,  5'd0},
    '{5'd18, 5'd17, 5'd0,  5'd0,  5'd0},
    '{5'd0,  5'd0,  5'd0,  5'd0,  5'd0},
    '{5'd2,  5'd6,  5'd3,  5'd4,  5'd5},
    '{5'd20, 5'd19, 5'd0,  5'd0,  5'd0},
    '{5'd21, 5'd0,  5'd0,  5'd0,  5'd0},
    '{5'd22, 5'd0,  5'd0,  5'd0,  5'd0},
    '{5'd23, 5'd0,  5'd0,  5'd0,  5'd0},
    '{5'd6,  5'd7,  5'd24, 5'd5,  5'd0},
    '{5'd8,  5'd9,  5'd6,  5'd10, 5'd5},
    '{5'd11, 5'd9,  5'd24, 5'd10, 5'd5},
    '{5'd26, 5'd25, 5'd0,  5'd0,  5'd0},
    '{5'd12, 5'd26, 5'd25, 5'd0,  5'd0},
    '{5'd28, 5'd27, 5'd0,  5'd0,  5'd0},
    '{5'd13, 5'd28, 5'd27, 5'd0,  5'd0},
    '{5'd6,  5'd0,  5'd0,  5'd0,  5'd0},
    '{5'd14, 5'd0,  5'd0,  5'd0,  5'd0},
    '{5'd9,  5'd24, 5'd10, 5'd0,  5'd0}
  };

  // Parse table: row is the nonterminal, column the token; 31 means no rule.
  localparam rule_idx_t PARSE_TABLE [13][16] = '{
    '{5'd0,  5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31,
      5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31},
    '{5'd31, 5'd2,  5'd1,  5'd31, 5'd31, 5'd31, 5'd2,  5'd31,
      5'd2,  5'd31, 5'd31, 5'd2,  5'd31, 5'd31, 5'd31, 5'd31},
    '{5'd31, 5'd31, 5'd3,  5'd31, 5'd31, 5'd31, 5'd31, 5'd31,
      5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31},
    '{5'd31, 5'd2,  5'd31, 5'd31, 5'd31, 5'd31, 5'd4,  5'd31,
      5'd4,  5'd31, 5'd31, 5'd4,  5'd31, 5'd31, 5'd31, 5'd31},
    '{5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 5'd5,  5'd31,
      5'd6,  5'd31, 5'd31, 5'd7,  5'd31, 5'd31, 5'd31, 5'd31},
    '{5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 5'd8,  5'd31,
      5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31},
    '{5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31,
      5'd9,  5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31},
    '{5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31,
      5'd31, 5'd31, 5'd31, 5'd10, 5'd31, 5'd31, 5'd31, 5'd31},
    '{5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 5'd11, 5'd31,
      5'd31, 5'd11, 5'd31, 5'd31, 5'd31, 5'd31, 5'd11, 5'd31},
    '{5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 5'd2,  5'd31, 5'd31,
      5'd31, 5'd31, 5'd2,  5'd31, 5'd12, 5'd31, 5'd31, 5'd31},
    '{5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 5'd13, 5'd31,
      5'd31, 5'd13, 5'd31, 5'd31, 5'd31, 5'd31, 5'd13, 5'd31},
    '{5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 5'd2,  5'd31, 5'd31,
      5'd31, 5'd31, 5'd2,  5'd31, 5'd2,  5'd14, 5'd31, 5'd31},
    '{5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 5'd15, 5'd31,
      5'd31, 5'd17, 5'd31, 5'd31, 5'd31, 5'd31, 5'd16, 5'd31}
  };

endpackage

// ----- src/ll1tsr_ifs.sv -----
// Valid/ready channel interfaces for the token input and the parse result output.
interface ll1tsr_tok_if;
  logic       valid;
  logic       ready;
  logic       start_flag;
  logic [3:0] token_code;

  modport source (output valid, output start_flag, output token_code, input ready);
  modport sink (input valid, input start_flag, input token_code, output ready);
endinterface

interface ll1tsr_res_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [4:0] expected_symbol;

  modport source (output valid, output status, output expected_symbol, input ready);
  modport sink (input valid, input status, input expected_symbol, output ready);
endinterface

// ----- src/ll1_token_stream_recognizer.sv -----
// LL(1) recognizer top level: symbol stack memory, stack pointer unit and parse sequencer.
//
// Takes one token item at a time and returns one result item per token. A small sequencer
// drives a single-port symbol stack (one write or one registered read per cycle) and one
// stack pointer adder/compare. An accepted token goes through S_INIT when start_flag is set,
// then S_FETCH (stack read) and S_EVAL; each nonterminal expansion on the way passes through
// S_PUSH once per pushed symbol and returns to S_FETCH. A token that is ignored while waiting
// for start goes straight from idle to S_DONE, where every token's result is loaded into an
// output register once it is free. The result waits there, and the next token is accepted
// only once the sequencer is back in idle, not while the last one is still in progress. The
// stack needs no clearing after reset.
module ll1_token_stream_recognizer
  import ll1tsr_pkg::*;
#(
  parameter int STACK_DEPTH = 128
) (
  input logic          clk,
  input logic          rst,
  ll1tsr_tok_if.sink   token_ch,
  ll1tsr_res_if.source result_ch
);

  localparam int AW  = $clog2(STACK_DEPTH);
  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam logic [SPW:0] DEPTH_EXT = (SPW + 1)'(STACK_DEPTH);

  // Symbol stack memory.
  sym_t            stack_mem [STACK_DEPTH];
  sym_t            rd_data;
  logic            rd_en;
  logic [AW-1:0]   rd_addr;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  sym_t            wr_data;

  // Sequencer and datapath registers.
  state_t          state;
  state_t          state_next;
  logic [SPW-1:0]  sp;
  logic [SPW-1:0]  sp_next;
  logic            parse_ended;
  logic            parse_ended_next;
  logic [3:0]      tok;
  logic [3:0]      tok_next;
  rule_idx_t       rule_idx;
  rule_idx_t       rule_idx_next;
  rule_len_t       push_cnt;
  rule_len_t       push_cnt_next;
  status_t         res_status;
  status_t         res_status_next;
  sym_t            res_symbol;
  sym_t            res_symbol_next;
  logic            out_valid;
  logic            out_valid_next;
  status_t         out_status;
  status_t         out_status_next;
  sym_t            out_symbol;
  sym_t            out_symbol_next;

  // Shared stack pointer unit and table lookup.
  logic            accept;
  logic            out_free;
  logic [SPW-1:0]  sp_dec;
  logic            nt_ok;
  rule_idx_t       rule_sel;
  logic            rule_ok;
  rule_len_t       rule_len;
  logic [SPW:0]    sp_need;

  assign accept   = token_ch.valid && token_ch.ready;
  assign out_free = !out_valid || result_ch.ready;
  assign token_ch.ready = (state == S_IDLE);

  assign result_ch.valid           = out_valid;
  assign result_ch.status          = out_status;
  assign result_ch.expected_symbol = out_symbol;

  assign sp_dec   = sp - SPW'(1);
  assign nt_ok    = rd_data[4] && (rd_data[3:0] < NT_COUNT);
  assign rule_sel = nt_ok ? PARSE_TABLE[rd_data[3:0]][tok] : RULE_NONE;
  assign rule_ok  = rule_sel < RULE_COUNT;
  assign rule_len = rule_ok ? RULE_LEN[rule_sel] : 3'd0;
  assign sp_need  = {1'b0, sp_dec} + (SPW + 1)'(rule_len);

  // Stack memory: one write or one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      stack_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= stack_mem[rd_addr];
    end
  end

  // Next state of the sequencer.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (token_ch.start_flag) begin
            state_next = S_INIT;
          end else if (parse_ended) begin
            state_next = S_DONE;
          end else begin
            state_next = S_FETCH;
          end
        end
      end
      S_INIT: state_next = S_FETCH;
      S_FETCH: begin
        state_next = (sp == '0) ? S_DONE : S_EVAL;
      end
      S_EVAL: begin
        if (!rd_data[4] || !rule_ok || (sp_need > DEPTH_EXT)) begin
          state_next = S_DONE;
        end else if (rule_len == 3'd0) begin
          state_next = S_FETCH;
        end else begin
          state_next = S_PUSH;
        end
      end
      S_PUSH: begin
        if (push_cnt == 3'd1) begin
          state_next = S_FETCH;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Datapath controls and register updates for each state.
  always_comb begin
    rd_en            = 1'b0;
    rd_addr          = sp_dec[AW-1:0];
    wr_en            = 1'b0;
    wr_addr          = sp[AW-1:0];
    wr_data          = RULE_SYM[rule_idx][push_cnt - 3'd1];
    sp_next          = sp;
    parse_ended_next = parse_ended;
    tok_next         = tok;
    rule_idx_next    = rule_idx;
    push_cnt_next    = push_cnt;
    res_status_next  = res_status;
    res_symbol_next  = res_symbol;
    out_valid_next   = out_valid && !result_ch.ready;
    out_status_next  = out_status;
    out_symbol_next  = out_symbol;
    case (state)
      S_IDLE: begin
        if (accept) begin
          tok_next        = token_ch.token_code;
          res_status_next = ST_IGNORED;
          res_symbol_next = SYM_ZERO;
          // Start of a new parse: end marker goes to the bottom entry.
          if (token_ch.start_flag) begin
            wr_en   = 1'b1;
            wr_addr = '0;
            wr_data = SYM_END;
          end
        end
      end
      S_INIT: begin
        wr_en            = 1'b1;
        wr_addr          = AW'(1);
        wr_data          = SYM_START;
        sp_next          = SPW'(2);
        parse_ended_next = 1'b0;
      end
      S_FETCH: begin
        // An empty stack reads as a mismatch against the end marker.
        if (sp == '0) begin
          parse_ended_next = 1'b1;
          res_status_next  = ST_MISMATCH;
          res_symbol_next  = SYM_END;
        end else begin
          rd_en = 1'b1;
        end
      end
      S_EVAL: begin
        if (!rd_data[4]) begin
          // Terminal on top: accept, consume or mismatch.
          if ((rd_data == SYM_END) && (tok == SYM_END[3:0])) begin
            parse_ended_next = 1'b1;
            res_status_next  = ST_ACCEPTED;
            res_symbol_next  = SYM_ZERO;
          end else if (rd_data == {1'b0, tok}) begin
            sp_next         = sp_dec;
            res_status_next = ST_CONSUMED;
            res_symbol_next = SYM_ZERO;
          end else begin
            parse_ended_next = 1'b1;
            res_status_next  = ST_MISMATCH;
            res_symbol_next  = rd_data;
          end
        end else if (!rule_ok) begin
          parse_ended_next = 1'b1;
          res_status_next  = ST_NO_RULE;
          res_symbol_next  = rd_data;
        end else if (sp_need > DEPTH_EXT) begin
          parse_ended_next = 1'b1;
          res_status_next  = ST_OVERFLOW;
          res_symbol_next  = rd_data;
        end else begin
          // Pop the nonterminal and start pushing its production from the right.
          sp_next       = sp_dec;
          rule_idx_next = rule_sel;
          push_cnt_next = rule_len;
        end
      end
      S_PUSH: begin
        wr_en         = 1'b1;
        sp_next       = sp + SPW'(1);
        push_cnt_next = push_cnt - 3'd1;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_next  = 1'b1;
          out_status_next = res_status;
          out_symbol_next = res_symbol;
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers take reset; payload registers do not.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      sp          <= '0;
      parse_ended <= 1'b1;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      sp          <= sp_next;
      parse_ended <= parse_ended_next;
      out_valid   <= out_valid_next;
    end
    tok        <= tok_next;
    rule_idx   <= rule_idx_next;
    push_cnt   <= push_cnt_next;
    res_status <= res_status_next;
    res_symbol <= res_symbol_next;
    out_status <= out_status_next;
    out_symbol <= out_symbol_next;
  end

endmodule

// ----- dv/ll1tsr_parse_checker.sv -----
// Checker for the LL(1) recognizer: predicts each token's result and compares the result items.
`timescale 1ns / 1ps
module ll1tsr_parse_checker
  import ll1tsr_pkg::*;
#(
  parameter int STACK_DEPTH = 128
) (
  input  logic  clk,
  input  logic  rst,
  ll1tsr_tok_if tok,
  ll1tsr_res_if res,
  output int    fail_count,
  output int    pending
);

  typedef struct {
    status_t status;
    sym_t    symbol;
  } parse_result_t;

  // Codes at and above this value are nonterminals.
  localparam int NT_FIRST = 16;
  localparam rule_idx_t NR = RULE_NONE;

  // Grammar productions: length and right-hand side, left to right.
  localparam rule_len_t PROD_LEN [18] = '{
    4, 2, 0, 5, 2, 1, 1, 1, 4, 5, 5, 2, 3, 2, 3, 1, 1, 3
  };

  localparam sym_t PROD_RHS [18][PROD_MAX] = '{
    '{0, 17, 19, 1, 0},
    '{18, 17, 0, 0, 0},
    '{0, 0, 0, 0, 0},
    '{2, 6, 3, 4, 5},
    '{20, 19, 0, 0, 0},
    '{21, 0, 0, 0, 0},
    '{22, 0, 0, 0, 0},
    '{23, 0, 0, 0, 0},
    '{6, 7, 24, 5, 0},
    '{8, 9, 6, 10, 5},
    '{11, 9, 24, 10, 5},
    '{26, 25, 0, 0, 0},
    '{12, 26, 25, 0, 0},
    '{28, 27, 0, 0, 0},
    '{13, 28, 27, 0, 0},
    '{6, 0, 0, 0, 0},
    '{14, 0, 0, 0, 0},
    '{9, 24, 10, 0, 0}
  };

  // Production selected by (nonterminal, lookahead token).
  localparam rule_idx_t SELECT [13][16] = '{
    '{ 0, NR, NR, NR, NR, NR, NR, NR, NR, NR, NR, NR, NR, NR, NR, NR},
    '{NR,  2,  1, NR, NR, NR,  2, NR,  2, NR, NR,  2, NR, NR, NR, NR},
    '{NR, NR,  3, NR, NR, NR, NR, NR, NR, NR, NR, NR, NR, NR, NR, NR},
    '{NR,  2, NR, NR, NR, NR,  4, NR,  4, NR, NR,  4, NR, NR, NR, NR},
    '{NR, NR, NR, NR, NR, NR,  5, NR,  6, NR, NR,  7, NR, NR, NR, NR},
    '{NR, NR, NR, NR, NR, NR,  8, NR, NR, NR, NR, NR, NR, NR, NR, NR},
    '{NR, NR, NR, NR, NR, NR, NR, NR,  9, NR, NR, NR, NR, NR, NR, NR},
    '{NR, NR, NR, NR, NR, NR, NR, NR, NR, NR, NR, 10, NR, NR, NR, NR},
    '{NR, NR, NR, NR, NR, NR, 11, NR, NR, 11, NR, NR, NR, NR, 11, NR},
    '{NR, NR, NR, NR, NR,  2, NR, NR, NR, NR,  2, NR, 12, NR, NR, NR},
    '{NR, NR, NR, NR, NR, NR, 13, NR, NR, 13, NR, NR, NR, NR, 13, NR},
    '{NR, NR, NR, NR, NR,  2, NR, NR, NR, NR,  2, NR,  2, 14, NR, NR},
    '{NR, NR, NR, NR, NR, NR, 15, NR, NR, 17, NR, NR, NR, NR, 16, NR}
  };

  // Predicted parser state.
  sym_t          sym_stack [STACK_DEPTH];
  int            depth;
  logic          ended;
  parse_result_t expected_q [$];
  int            fails = 0;

  assign fail_count = fails;
  assign pending    = expected_q.size();

  // Runs one token through the predicted stack and returns its result.
  function automatic void predict_token(input logic start, input logic [3:0] code,
                                        output parse_result_t outcome);
    int        top_sym;
    int        row;
    rule_idx_t prod;
    int        len;
    bit        busy;
    outcome.status = ST_IGNORED;
    outcome.symbol = SYM_ZERO;
    if (start) begin
      sym_stack[0] = SYM_END;
      sym_stack[1] = SYM_START;
      depth = 2;
      ended = 1'b0;
    end
    busy = !ended;
    while (busy) begin
      busy = 1'b0;
      if (depth == 0 || depth > STACK_DEPTH) begin
        ended = 1'b1;
        outcome.status = ST_MISMATCH;
        outcome.symbol = SYM_END;
      end else begin
        top_sym = int'(sym_stack[depth - 1]);
        if (top_sym < NT_FIRST) begin
          // A terminal on top must match the token; the end marker accepts.
          if (top_sym == int'(SYM_END) && code == SYM_END[3:0]) begin
            ended = 1'b1;
            outcome.status = ST_ACCEPTED;
          end else if (top_sym == int'(code)) begin
            depth--;
            outcome.status = ST_CONSUMED;
          end else begin
            ended = 1'b1;
            outcome.status = ST_MISMATCH;
            outcome.symbol = sym_t'(top_sym);
          end
        end else begin
          row  = top_sym - NT_FIRST;
          prod = (row < int'(NT_COUNT)) ? SELECT[row][code] : NR;
          if (prod >= RULE_COUNT) begin
            ended = 1'b1;
            outcome.status = ST_NO_RULE;
            outcome.symbol = sym_t'(top_sym);
          end else begin
            len = int'(PROD_LEN[prod]);
            if (depth - 1 + len > STACK_DEPTH) begin
              // Nothing of the production is pushed; the nonterminal stays.
              ended = 1'b1;
              outcome.status = ST_OVERFLOW;
              outcome.symbol = sym_t'(top_sym);
            end else begin
              // Replace the nonterminal, rightmost symbol pushed first.
              depth--;
              for (int i = len; i > 0; i--) begin
                sym_stack[depth] = PROD_RHS[prod][i - 1];
                depth++;
              end
              busy = 1'b1;
            end
          end
        end
      end
    end
  endfunction

  // Compare delivered result items, then queue the prediction for an accepted token item.
  always @(posedge clk) begin
    parse_result_t want;
    if (rst) begin
      depth = 0;
      ended = 1'b1;
      expected_q.delete();
    end else begin
      if (res.valid && res.ready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result item: status %0d, expected_symbol %0d",
                 res.status, res.expected_symbol);
          fails++;
        end else begin
          want = expected_q.pop_front();
          if (res.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, res.status);
            fails++;
          end
          if (res.expected_symbol !== want.symbol) begin
            $error("expected_symbol: expected %0d, actual %0d",
                   want.symbol, res.expected_symbol);
            fails++;
          end
        end
      end
      if (tok.valid && tok.ready) begin
        predict_token(tok.start_flag, tok.token_code, want);
        expected_q.push_back(want);
      end
    end
  end

endmodule

// ----- dv/ll1_token_stream_recognizer_test.sv -----
// Testbench top for the LL(1) recognizer: clock, reset, token stimulus, result flow control and verdict.
`timescale 1ns / 1ps
module ll1_token_stream_recognizer_test;

  localparam int DEPTH        = 128;
  localparam int RANDOM_ITEMS = 1600;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 40;

  // Terminal codes in grammar order; the last one is the end marker.
  typedef enum logic [3:0] {
    T_DEBUT_PROG, T_FIN_PROG, T_DECLARER, T_DEUX_POINTS, T_ENTIER, T_POINT_VIRGULE,
    T_ID, T_AFFECT, T_LIRE, T_PAREN_OUV, T_PAREN_FERM, T_AFFICHER, T_PLUS, T_MULT,
    T_ENTIER_LIT, T_EOF
  } token_t;

  typedef struct packed {
    logic   start;
    token_t code;
  } token_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count;
  int   pending;
  int   cycle_count = 0;
  int   rx_hold = 0;
  int   rx_stall_pct = 30;
  int   tx_mode = 1;
  token_item_t stim_q [$];

  ll1tsr_tok_if tok_ch ();
  ll1tsr_res_if res_ch ();

  ll1_token_stream_recognizer #(.STACK_DEPTH(DEPTH)) dut (
    .clk       (clk),
    .rst       (rst),
    .token_ch  (tok_ch),
    .result_ch (res_ch)
  );

  ll1tsr_parse_checker #(.STACK_DEPTH(DEPTH)) parse_chk (
    .clk        (clk),
    .rst        (rst),
    .tok        (tok_ch),
    .res        (res_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stop a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Result side: random stalls, rate changing over time, plus a requested long hold-off.
  initial begin
    int stall_left;
    int cyc;
    stall_left = 0;
    cyc = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc % 300 == 0) begin
        case ($urandom_range(0, 2))
          0: rx_stall_pct = 0;
          1: rx_stall_pct = 15;
          default: rx_stall_pct = 40;
        endcase
      end
      if (rx_hold > 0) begin
        res_ch.ready = 1'b0;
        rx_hold--;
      end else if (stall_left > 0) begin
        res_ch.ready = 1'b0;
        stall_left--;
      end else if ($urandom_range(0, 99) < rx_stall_pct) begin
        res_ch.ready = 1'b0;
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                 : $urandom_range(0, 2);
      end else begin
        res_ch.ready = 1'b1;
      end
    end
  end

  task automatic add(input logic start, input token_t code);
    token_item_t it;
    it.start = start;
    it.code  = code;
    stim_q.push_back(it);
  endtask

  // Idle cycles before the next token item: none in a burst, else mostly short.
  function automatic int pick_gap();
    int r;
    if (tx_mode == 0) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer every queued token item in order and wait for each handshake.
  task automatic send_queue();
    int gap;
    foreach (stim_q[i]) begin
      gap = pick_gap();
      if (gap > 0) begin
        tok_ch.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      tok_ch.valid      = 1'b1;
      tok_ch.start_flag = stim_q[i].start;
      tok_ch.token_code = stim_q[i].code;
      do @(posedge clk); while (!tok_ch.ready);
      @(negedge clk);
    end
    // The last item has been taken; stop offering it.
    tok_ch.valid = 1'b0;
    stim_q.delete();
  endtask

  task automatic wait_drained();
    while (pending != 0) @(negedge clk);
  endtask

  // Well-formed expression with random operators and up to three levels of parentheses.
  task automatic add_expr();
    int nest;
    int pick;
    bit want_operand;
    bit done;
    nest = 0;
    want_operand = 1'b1;
    done = 1'b0;
    while (!done) begin
      if (want_operand) begin
        if (nest < 3 && $urandom_range(0, 4) == 0) begin
          add(1'b0, T_PAREN_OUV);
          nest++;
        end else begin
          add(1'b0, $urandom_range(0, 1) ? T_ID : T_ENTIER_LIT);
          want_operand = 1'b0;
        end
      end else begin
        pick = $urandom_range(0, 3);
        if (pick == 0) begin
          add(1'b0, T_PLUS);
          want_operand = 1'b1;
        end else if (pick == 1) begin
          add(1'b0, T_MULT);
          want_operand = 1'b1;
        end else if (nest > 0) begin
          add(1'b0, T_PAREN_FERM);
          nest--;
        end else begin
          done = 1'b1;
        end
      end
    end
  endtask

  // Whole program; some get one corrupted token and are cut short at most two tokens after it.
  task automatic add_program();
    int pos;
    int keep;
    add(1'b1, T_DEBUT_PROG);
    repeat ($urandom_range(0, 3)) begin
      add(1'b0, T_DECLARER);
      add(1'b0, T_ID);
      add(1'b0, T_DEUX_POINTS);
      add(1'b0, T_ENTIER);
      add(1'b0, T_POINT_VIRGULE);
    end
    repeat ($urandom_range(0, 4)) begin
      case ($urandom_range(0, 2))
        0: begin
          add(1'b0, T_ID);
          add(1'b0, T_AFFECT);
          add_expr();
        end
        1: begin
          add(1'b0, T_LIRE);
          add(1'b0, T_PAREN_OUV);
          add(1'b0, T_ID);
          add(1'b0, T_PAREN_FERM);
        end
        default: begin
          add(1'b0, T_AFFICHER);
          add(1'b0, T_PAREN_OUV);
          add_expr();
          add(1'b0, T_PAREN_FERM);
        end
      endcase
      add(1'b0, T_POINT_VIRGULE);
    end
    add(1'b0, T_FIN_PROG);
    add(1'b0, T_EOF);
    if ($urandom_range(0, 99) < 30) begin
      pos = $urandom_range(1, stim_q.size() - 1);
      stim_q[pos].code = token_t'($urandom_range(0, 15));
      keep = pos + 1 + $urandom_range(0, 2);
      while (stim_q.size() > keep) void'(stim_q.pop_back());
    end
    // Occasionally drop the start flag or restart in the middle of the program.
    if ($urandom_range(0, 99) < 5) stim_q[0].start = 1'b0;
    if ($urandom_range(0, 99) < 5) stim_q[$urandom_range(1, stim_q.size() - 1)].start = 1'b1;
  endtask

  // Deeply nested parentheses; the deeper ones run out of stack.
  task automatic add_deep_nesting();
    int levels;
    levels = $urandom_range(30, 48);
    add(1'b1, T_DEBUT_PROG);
    add(1'b0, T_ID);
    add(1'b0, T_AFFECT);
    repeat (levels) add(1'b0, T_PAREN_OUV);
    add(1'b0, T_ID);
    repeat (levels) add(1'b0, T_PAREN_FERM);
    add(1'b0, T_POINT_VIRGULE);
    add(1'b0, T_FIN_PROG);
    add(1'b0, T_EOF);
  endtask

  // Arbitrary token items with random start flags.
  task automatic add_noise();
    repeat ($urandom_range(1, 8))
      add(($urandom_range(0, 3) == 0), token_t'($urandom_range(0, 15)));
  endtask

  // Stimulus and verdict.
  initial begin
    int items_sent;
    int pick;
    bit held;
    bit paused;
    tok_ch.valid      = 1'b0;
    tok_ch.start_flag = 1'b0;
    tok_ch.token_code = '0;
    repeat (5) @(negedge clk);
    rst = 1'b0;

    // Token before any start is ignored.
    add(1'b0, T_ID);
    // Empty program is accepted; the next token is ignored again.
    add(1'b1, T_DEBUT_PROG);
    add(1'b0, T_FIN_PROG);
    add(1'b0, T_EOF);
    add(1'b0, T_EOF);
    // End of input at the start symbol has no rule.
    add(1'b1, T_EOF);
    // Restart in the middle of a parse, then a declaration and an assignment.
    add(1'b1, T_DEBUT_PROG);
    add(1'b1, T_DEBUT_PROG);
    add(1'b0, T_DECLARER);
    add(1'b0, T_ID);
    add(1'b0, T_DEUX_POINTS);
    add(1'b0, T_ENTIER);
    add(1'b0, T_POINT_VIRGULE);
    add(1'b0, T_ID);
    add(1'b0, T_AFFECT);
    add(1'b0, T_ENTIER_LIT);
    add(1'b0, T_MULT);
    add(1'b0, T_ID);
    add(1'b0, T_PLUS);
    add(1'b0, T_ID);
    add(1'b0, T_POINT_VIRGULE);
    add(1'b0, T_FIN_PROG);
    add(1'b0, T_EOF);
    // Terminal mismatch: a declaration keyword where an identifier belongs.
    add(1'b1, T_DEBUT_PROG);
    add(1'b0, T_DECLARER);
    add(1'b0, T_DECLARER);
    send_queue();
    wait_drained();

    // Random sequences, mostly well-formed programs.
    items_sent = 0;
    held = 1'b0;
    paused = 1'b0;
    while (items_sent < RANDOM_ITEMS) begin
      tx_mode = ($urandom_range(0, 9) < 3) ? 0 : 1;
      pick = $urandom_range(0, 99);
      if (pick < 75) add_program();
      else if (pick < 85) add_deep_nesting();
      else add_noise();
      items_sent += stim_q.size();
      send_queue();
      // Long receiver hold-off while items keep coming.
      if (!held && items_sent >= 500) begin
        rx_hold = 400;
        held = 1'b1;
      end
      // Sender pause until all results are back.
      if (!paused && items_sent >= 1000) begin
        wait_drained();
        paused = 1'b1;
      end
    end
    tok_ch.valid = 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
